@@ rtl/asbc_pkg.sv @@
package asbc_pkg;

   // Field and register widths fixed by the interface
   localparam int THR_BITS   = 16;
   localparam int STILL_BITS = 8;
   localparam int QC_BITS    = STILL_BITS + 1;
   localparam int MODE_BITS  = 2;
   localparam int DATA_BITS  = 32;
   localparam int ADDR_BITS  = 3;
   localparam int AXES       = 3;

   // Parameter defaults
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_WINDOW_DEF  = 255;

   // Largest window the still_samples register can express
   localparam int WIN_LIMIT = (2 ** STILL_BITS) - 1;

   // Register reset values
   localparam logic [THR_BITS-1:0]   THR_RESET   = 16'd50;
   localparam logic [STILL_BITS-1:0] STILL_RESET = 8'd50;

   // Register indexes
   localparam logic [0:0] REG_MOTION_THRESHOLD = 1'b0;
   localparam logic [0:0] REG_STILL_SAMPLES    = 1'b1;

   // Calibration mode codes
   localparam logic [MODE_BITS-1:0] MODE_MOVING     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_AVERAGING  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CALIBRATED = 2'd2;

   // Lane commands: parallel load, one serial step, take the trial sum, zero the sum
   typedef struct packed {
      logic load;
      logic step;
      logic commit;
      logic clear;
   } lane_ctrl_type;

   // Divider commands
   typedef struct packed {
      logic start;
      logic step;
   } div_ctrl_type;

   // Serial word length: wide enough for the running sum and the threshold compare
   function automatic int pass_bits(input int sample_bits, input int max_window);
      int cap;
      int sum_w;
      int cmp_w;
      cap   = (max_window > WIN_LIMIT) ? WIN_LIMIT : max_window;
      sum_w = sample_bits + $clog2(cap + 1) + 1;
      cmp_w = ((sample_bits > THR_BITS) ? sample_bits : THR_BITS) + 3;
      return (sum_w > cmp_w) ? sum_w : cmp_w;
   endfunction

endpackage

@@ rtl/asbc_axis_lane.sv @@
module asbc_axis_lane #(
   parameter int SAMPLE_BITS = asbc_pkg::SAMPLE_BITS_DEF,
   parameter int PASS_BITS   = asbc_pkg::pass_bits(SAMPLE_BITS, asbc_pkg::MAX_WINDOW_DEF)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  asbc_pkg::lane_ctrl_type              ctrl,
   input  logic signed [SAMPLE_BITS-1:0]        sample,
   input  logic [asbc_pkg::THR_BITS-1:0]        threshold,
   output logic                                 moved,
   output logic signed [PASS_BITS-1:0]          sum
);

   logic signed [SAMPLE_BITS-1:0] last_ff, last_in;
   logic [PASS_BITS-1:0] sum_ff, sum_in;
   logic [PASS_BITS-1:0] cur_sr_ff, cur_sr_in;
   logic [PASS_BITS-1:0] last_sr_ff, last_sr_in;
   logic [PASS_BITS-1:0] thr_sr_ff, thr_sr_in;
   logic [PASS_BITS-1:0] trial_ff, trial_in;
   logic cd_ff, cd_in, cp_ff, cp_in, cq_ff, cq_in, ca_ff, ca_in;
   logic p_ff, p_in, q_ff, q_in;

   logic c_bit, nl_bit, t_bit, s_bit;
   logic d_bit, nd_bit, p_bit, q_bit, a_bit;

   // Serial bit slices: d = cur - last, p = thr - d, q = d + thr, a = sum + cur
   always_comb begin
      c_bit  = cur_sr_ff[0];
      nl_bit = ~last_sr_ff[0];
      t_bit  = thr_sr_ff[0];
      s_bit  = sum_ff[0];
      d_bit  = c_bit ^ nl_bit ^ cd_ff;
      nd_bit = ~d_bit;
      p_bit  = t_bit ^ nd_bit ^ cp_ff;
      q_bit  = d_bit ^ t_bit ^ cq_ff;
      a_bit  = s_bit ^ c_bit ^ ca_ff;
   end

   // Next-state of the lane
   always_comb begin
      last_in    = last_ff;
      sum_in     = sum_ff;
      cur_sr_in  = cur_sr_ff;
      last_sr_in = last_sr_ff;
      thr_sr_in  = thr_sr_ff;
      trial_in   = trial_ff;
      cd_in      = cd_ff;
      cp_in      = cp_ff;
      cq_in      = cq_ff;
      ca_in      = ca_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      if (ctrl.load) begin
         // capture the transfer, remember it as the previous sample
         cur_sr_in  = {{(PASS_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
         last_sr_in = {{(PASS_BITS-SAMPLE_BITS){last_ff[SAMPLE_BITS-1]}}, last_ff};
         thr_sr_in  = {{(PASS_BITS-asbc_pkg::THR_BITS){1'b0}}, threshold};
         last_in    = sample;
         cd_in      = 1'b1;
         cp_in      = 1'b1;
         cq_in      = 1'b0;
         ca_in      = 1'b0;
      end
      if (ctrl.step) begin
         // advance one bit, LSB first; the sum rotates back to itself
         cur_sr_in  = {1'b0, cur_sr_ff[PASS_BITS-1:1]};
         last_sr_in = {1'b0, last_sr_ff[PASS_BITS-1:1]};
         thr_sr_in  = {1'b0, thr_sr_ff[PASS_BITS-1:1]};
         sum_in     = {sum_ff[0], sum_ff[PASS_BITS-1:1]};
         trial_in   = {a_bit, trial_ff[PASS_BITS-1:1]};
         cd_in      = (c_bit & nl_bit) | (c_bit & cd_ff) | (nl_bit & cd_ff);
         cp_in      = (t_bit & nd_bit) | (t_bit & cp_ff) | (nd_bit & cp_ff);
         cq_in      = (d_bit & t_bit) | (d_bit & cq_ff) | (t_bit & cq_ff);
         ca_in      = (s_bit & c_bit) | (s_bit & ca_ff) | (c_bit & ca_ff);
         p_in       = p_bit;
         q_in       = q_bit;
      end
      if (ctrl.commit) begin
         sum_in = trial_ff;
      end
      if (ctrl.clear) begin
         sum_in = '0;
      end
   end

   // Model state: previous sample and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         sum_ff  <= '0;
      end else begin
         last_ff <= last_in;
         sum_ff  <= sum_in;
      end
   end

   // Shift registers and carries
   always_ff @(posedge clock) begin
      cur_sr_ff  <= cur_sr_in;
      last_sr_ff <= last_sr_in;
      thr_sr_ff  <= thr_sr_in;
      trial_ff   <= trial_in;
      cd_ff      <= cd_in;
      cp_ff      <= cp_in;
      cq_ff      <= cq_in;
      ca_ff      <= ca_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
   end

   // Sign bits of thr - d and d + thr after the last step
   assign moved = p_ff | q_ff;
   assign sum   = sum_ff;

endmodule

@@ rtl/asbc_serial_div.sv @@
module asbc_serial_div #(
   parameter int SAMPLE_BITS = asbc_pkg::SAMPLE_BITS_DEF,
   parameter int PASS_BITS   = asbc_pkg::pass_bits(SAMPLE_BITS, asbc_pkg::MAX_WINDOW_DEF)
) (
   input  logic                                 clock,
   input  asbc_pkg::div_ctrl_type               ctrl,
   input  logic signed [PASS_BITS-1:0]          dividend,
   input  logic [asbc_pkg::STILL_BITS-1:0]      divisor,
   output logic signed [SAMPLE_BITS-1:0]        quotient
);

   logic neg_ff, neg_in;
   logic [PASS_BITS-1:0] mag_ff, mag_in;
   logic [PASS_BITS-1:0] quo_ff, quo_in;
   logic [asbc_pkg::STILL_BITS-1:0] rem_ff, rem_in;
   logic [asbc_pkg::STILL_BITS:0] shifted, diff;
   logic ge;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, mag_ff[PASS_BITS-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
   end

   always_comb begin
      neg_in = neg_ff;
      mag_in = mag_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (ctrl.start) begin
         // divide magnitudes, fix the sign at the end
         neg_in = dividend[PASS_BITS-1];
         mag_in = dividend[PASS_BITS-1] ? (~dividend + {{(PASS_BITS-1){1'b0}}, 1'b1})
                                        : dividend;
         quo_in = '0;
         rem_in = '0;
      end else if (ctrl.step) begin
         mag_in = {mag_ff[PASS_BITS-2:0], 1'b0};
         quo_in = {quo_ff[PASS_BITS-2:0], ge};
         rem_in = ge ? diff[asbc_pkg::STILL_BITS-1:0] : shifted[asbc_pkg::STILL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // Truncation toward zero: negate the magnitude quotient for a negative sum
   assign quotient = neg_ff ? (~quo_ff[SAMPLE_BITS-1:0] + {{(SAMPLE_BITS-1){1'b0}}, 1'b1})
                            : quo_ff[SAMPLE_BITS-1:0];

endmodule

@@ rtl/accel_stillness_bias_calibrator_unit.sv @@
// A result is registered after each axis lane's serial pass, the decide state and the
//   output state; the sample ending calibration adds the serial divide and latch.
// One sample at a time: req_stall stays high until the last result is in the
//   output register. Each lane works bit-serially over the PASS_BITS-wide sum word.
// Reset: synchronous, active high; clears mode, counters, sums, biases and the previous
//   sample, and loads motion_threshold and still_samples with 50.
module accel_stillness_bias_calibrator_unit #(
   parameter int SAMPLE_BITS = asbc_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = asbc_pkg::MAX_WINDOW_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [asbc_pkg::MODE_BITS-1:0]        rsp_cal_mode,
   output logic signed [SAMPLE_BITS-1:0]         rsp_bias_x,
   output logic signed [SAMPLE_BITS-1:0]         rsp_bias_y,
   output logic signed [SAMPLE_BITS-1:0]         rsp_bias_z,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [asbc_pkg::ADDR_BITS-1:0]        paddr,
   input  logic [asbc_pkg::DATA_BITS-1:0]        pwdata,
   output logic [asbc_pkg::DATA_BITS-1:0]        prdata,
   output logic                                  pready
);

   localparam int PASS_BITS = asbc_pkg::pass_bits(SAMPLE_BITS, MAX_WINDOW);
   localparam int CNT_BITS  = $clog2(PASS_BITS);
   localparam int SB_W      = asbc_pkg::STILL_BITS;
   localparam int QC_W      = asbc_pkg::QC_BITS;
   localparam int WIN_CAP_I = (MAX_WINDOW > asbc_pkg::WIN_LIMIT) ? asbc_pkg::WIN_LIMIT
                                                                 : MAX_WINDOW;
   localparam logic [SB_W-1:0]     WIN_CAP   = WIN_CAP_I[SB_W-1:0];
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(PASS_BITS - 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PASS   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_LATCH  = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [QC_W-1:0] quiet_ff, quiet_in;
   logic [asbc_pkg::MODE_BITS-1:0] mode_ff, mode_in;
   logic signed [SAMPLE_BITS-1:0] bias_ff [asbc_pkg::AXES];
   logic signed [SAMPLE_BITS-1:0] bias_in [asbc_pkg::AXES];
   logic [asbc_pkg::THR_BITS-1:0] thr_ff, thr_in;
   logic [SB_W-1:0] still_ff, still_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [asbc_pkg::MODE_BITS-1:0] rsp_mode_ff, rsp_mode_in;
   logic signed [SAMPLE_BITS-1:0] rsp_bias_ff [asbc_pkg::AXES];
   logic signed [SAMPLE_BITS-1:0] rsp_bias_in [asbc_pkg::AXES];

   asbc_pkg::lane_ctrl_type lane_ctrl;
   asbc_pkg::div_ctrl_type  div_ctrl;
   logic signed [SAMPLE_BITS-1:0] sample [asbc_pkg::AXES];
   logic [asbc_pkg::AXES-1:0] moved_vec;
   logic signed [PASS_BITS-1:0] sum_vec [asbc_pkg::AXES];
   logic signed [SAMPLE_BITS-1:0] quo_vec [asbc_pkg::AXES];

   logic accept, out_free, calibrated, moved_any, csr_write;
   logic [SB_W-1:0] win_n;
   logic [QC_W-1:0] n_ext, twice_n;
   logic [0:0] reg_idx;

   assign sample[0] = req_accel_x;
   assign sample[1] = req_accel_y;
   assign sample[2] = req_accel_z;

   // Per-axis serial datapath
   for (genvar g = 0; g < asbc_pkg::AXES; g++) begin : g_axis
      asbc_axis_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .PASS_BITS   (PASS_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .sample    (sample[g]),
         .threshold (thr_ff),
         .moved     (moved_vec[g]),
         .sum       (sum_vec[g])
      );

      asbc_serial_div #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .PASS_BITS   (PASS_BITS)
      ) u_div (
         .clock    (clock),
         .ctrl     (div_ctrl),
         .dividend (sum_vec[g]),
         .divisor  (win_n),
         .quotient (quo_vec[g])
      );
   end

   // Handshake and window length
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      accept     = req_valid && !req_stall;
      out_free   = !rsp_valid_ff || !rsp_stall;
      calibrated = (mode_ff == asbc_pkg::MODE_CALIBRATED);
      moved_any  = |moved_vec;
      win_n      = (still_ff == '0) ? {{(SB_W-1){1'b0}}, 1'b1} : still_ff;
      if (win_n > WIN_CAP) begin
         win_n = WIN_CAP;
      end
      n_ext   = {1'b0, win_n};
      twice_n = {win_n, 1'b0};
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      quiet_in     = quiet_ff;
      mode_in      = mode_ff;
      bias_in      = bias_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_bias_in  = rsp_bias_ff;
      lane_ctrl    = '0;
      div_ctrl     = '0;

      // drop the result once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lane_ctrl.load = 1'b1;
               count_in       = '0;
               state_in       = ST_PASS;
            end
         end
         ST_PASS: begin
            lane_ctrl.step = 1'b1;
            count_in       = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_OUT;
            if (!calibrated && moved_any) begin
               // motion restarts the whole process
               quiet_in        = '0;
               mode_in         = asbc_pkg::MODE_MOVING;
               lane_ctrl.clear = 1'b1;
            end else if (quiet_ff < n_ext && !calibrated) begin
               quiet_in = quiet_ff + 1'b1;
            end else if (n_ext <= quiet_ff && quiet_ff < twice_n) begin
               mode_in          = asbc_pkg::MODE_AVERAGING;
               quiet_in         = quiet_ff + 1'b1;
               lane_ctrl.commit = 1'b1;
            end else if (quiet_ff == twice_n) begin
               // window complete: divide the sums, then latch
               div_ctrl.start  = 1'b1;
               lane_ctrl.clear = 1'b1;
               quiet_in        = '0;
               mode_in         = asbc_pkg::MODE_CALIBRATED;
               count_in        = '0;
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            div_ctrl.step = 1'b1;
            count_in      = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            bias_in  = quo_vec;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mode_in  = mode_ff;
               rsp_bias_in  = bias_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      reg_idx   = paddr[asbc_pkg::ADDR_BITS-1:2];
      csr_write = psel && penable && pwrite && pready;
      thr_in    = thr_ff;
      still_in  = still_ff;
      if (csr_write) begin
         case (reg_idx)
            asbc_pkg::REG_MOTION_THRESHOLD: thr_in   = pwdata[asbc_pkg::THR_BITS-1:0];
            asbc_pkg::REG_STILL_SAMPLES:    still_in = pwdata[SB_W-1:0];
            default: begin
               thr_in = thr_ff;
            end
         endcase
      end
   end

   // Configuration reads
   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         case (reg_idx)
            asbc_pkg::REG_MOTION_THRESHOLD:
               prdata = {{(asbc_pkg::DATA_BITS-asbc_pkg::THR_BITS){1'b0}}, thr_ff};
            asbc_pkg::REG_STILL_SAMPLES:
               prdata = {{(asbc_pkg::DATA_BITS-SB_W){1'b0}}, still_ff};
            default: begin
               prdata = '0;
            end
         endcase
      end
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         quiet_ff     <= '0;
         mode_ff      <= asbc_pkg::MODE_MOVING;
         bias_ff      <= '{default: '0};
         thr_ff       <= asbc_pkg::THR_RESET;
         still_ff     <= asbc_pkg::STILL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         quiet_ff     <= quiet_in;
         mode_ff      <= mode_in;
         bias_ff      <= bias_in;
         thr_ff       <= thr_in;
         still_ff     <= still_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_mode_ff <= rsp_mode_in;
      rsp_bias_ff <= rsp_bias_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cal_mode = rsp_mode_ff;
   assign rsp_bias_x   = rsp_bias_ff[0];
   assign rsp_bias_y   = rsp_bias_ff[1];
   assign rsp_bias_z   = rsp_bias_ff[2];

   // Calibrated mode is final until reset
   a_cal_holds: assert property (@(posedge clock) disable iff (reset)
      mode_ff == asbc_pkg::MODE_CALIBRATED |=> mode_ff == asbc_pkg::MODE_CALIBRATED)
      else $error("calibrated mode left");

   // The counter rests at zero once calibrated
   a_cal_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == asbc_pkg::MODE_CALIBRATED |-> quiet_ff == '0)
      else $error("quiet counter moved after calibration");

   // Biases stay zero until calibration completes
   a_bias_zero: assert property (@(posedge clock) disable iff (reset)
      mode_ff != asbc_pkg::MODE_CALIBRATED |->
         (bias_ff[0] == '0 && bias_ff[1] == '0 && bias_ff[2] == '0))
      else $error("bias latched before calibration");

   // A transfer always starts a serial pass
   a_accept_pass: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_PASS)
      else $error("accepted sample did not start a pass");

endmodule
